FILE: hw/rtl/htfc_pkg.sv
// Shared types and constants of the humidity/temperature frame checker.
package htfc_pkg;

   // Link status codes carried with each frame
   localparam logic [1:0] LINK_OK        = 2'd0;
   localparam logic [1:0] LINK_ADDR_NACK = 2'd1;
   localparam logic [1:0] LINK_CMDH_NACK = 2'd2;
   localparam logic [1:0] LINK_CMDL_NACK = 2'd3;

   // Configuration register indexes
   localparam logic CSR_CRC_POLY    = 1'b0;
   localparam logic CSR_ERROR_LIMIT = 1'b1;

   localparam logic [7:0] CRC_POLY_RESET    = 8'h31;
   localparam logic [7:0] ERROR_LIMIT_RESET = 8'd4;
   localparam logic [7:0] CRC_INIT          = 8'hFF;

   // Scaling: value = raw * SCALE / SCALE_DIV (+ offset for temperature)
   localparam int         TEMP_SCALE  = 175;
   localparam int         HUM_SCALE   = 100;
   localparam int         SCALE_DIV   = 65534;
   localparam logic [7:0] TEMP_OFFSET = 8'd5;
   localparam int         TEMP_MAX    = 180;
   localparam int         PROD_W      = 24;

   localparam int AVG_DEPTH_DEFAULT   = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] crc_poly;
      logic [7:0] error_limit;
   } htfc_cfg_type;

   typedef struct packed {
      logic [1:0]  link_status;
      logic [15:0] temp_word;
      logic [7:0]  temp_check;
      logic [15:0] hum_word;
      logic [7:0]  hum_check;
   } htfc_frame_type;

   // Classified frame handed from the front to the back
   typedef struct packed {
      logic [1:0] link_status;
      logic       temp_good;
      logic       hum_good;
      logic [7:0] temp_value;
      logic [6:0] hum_value;
   } htfc_item_type;

   typedef struct packed {
      logic [7:0] temp_average;
      logic [6:0] hum_average;
      logic       temp_good;
      logic       hum_good;
      logic       sensor_error;
      logic       reset_request;
   } htfc_result_type;

endpackage

FILE: hw/rtl/htfc_fifo.sv
// Small register-based first-in first-out queue.
module htfc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_write, do_read;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_write = push && !full;
   assign do_read  = pop && !empty;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hw/rtl/htfc_front.sv
// Front part: registers a frame, checks both CRCs and scales the raw words.
module htfc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  htfc_pkg::htfc_cfg_type  cfg,
   input  logic                    frame_valid,
   input  htfc_pkg::htfc_frame_type frame,
   output logic                    frame_full,
   output logic                    item_push,
   output htfc_pkg::htfc_item_type item,
   input  logic                    item_full
);

   localparam int          SCALE_PAD = (1 << 16) - htfc_pkg::SCALE_DIV;
   localparam logic [16:0] DIV_CMP   = 17'(htfc_pkg::SCALE_DIV);

   function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
      logic [7:0] crc;
      logic       top;
      crc = crc_in;
      for (int b = 7; b >= 0; b--) begin
         top = crc[7] ^ data[b];
         crc = {crc[6:0], 1'b0};
         if (top) begin
            crc = crc ^ poly;
         end
      end
      return crc;
   endfunction

   // Quotient by the 2^16-2 divisor: high part plus one correction step.
   function automatic logic [7:0] div_scale(input logic [23:0] prod);
      logic [7:0]  q0;
      logic [16:0] rem;
      q0  = prod[23:16];
      rem = {1'b0, prod[15:0]} + 17'(q0) * 17'(SCALE_PAD);
      return (rem >= DIV_CMP) ? q0 + 8'd1 : q0;
   endfunction

   logic        f1_valid_ff;
   logic [1:0]  f1_status_ff;
   logic [7:0]  f1_temp_crc_ff, f1_hum_crc_ff;
   logic [7:0]  f1_temp_low_ff, f1_hum_low_ff;
   logic [7:0]  f1_temp_check_ff, f1_hum_check_ff;
   logic [23:0] f1_temp_prod_ff, f1_hum_prod_ff;
   logic        f1_load;
   logic [7:0]  temp_crc, hum_crc, temp_scaled, hum_scaled;
   logic        link_ok;

   assign item_push  = f1_valid_ff && !item_full;
   assign frame_full = f1_valid_ff && item_full;
   assign f1_load    = frame_valid && !frame_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (f1_load) begin
         f1_valid_ff <= 1'b1;
      end else if (item_push) begin
         f1_valid_ff <= 1'b0;
      end
   end

   // The high byte of each word is folded into the CRC on the way in.
   always_ff @(posedge clock) begin
      if (f1_load) begin
         f1_status_ff     <= frame.link_status;
         f1_temp_crc_ff   <= crc_byte(htfc_pkg::CRC_INIT, frame.temp_word[15:8], cfg.crc_poly);
         f1_hum_crc_ff    <= crc_byte(htfc_pkg::CRC_INIT, frame.hum_word[15:8], cfg.crc_poly);
         f1_temp_low_ff   <= frame.temp_word[7:0];
         f1_hum_low_ff    <= frame.hum_word[7:0];
         f1_temp_check_ff <= frame.temp_check;
         f1_hum_check_ff  <= frame.hum_check;
         f1_temp_prod_ff  <= 24'(frame.temp_word) * 24'(htfc_pkg::TEMP_SCALE);
         f1_hum_prod_ff   <= 24'(frame.hum_word) * 24'(htfc_pkg::HUM_SCALE);
      end
   end

   always_comb begin
      temp_crc    = crc_byte(f1_temp_crc_ff, f1_temp_low_ff, cfg.crc_poly);
      hum_crc     = crc_byte(f1_hum_crc_ff, f1_hum_low_ff, cfg.crc_poly);
      temp_scaled = div_scale(f1_temp_prod_ff);
      hum_scaled  = div_scale(f1_hum_prod_ff);
      link_ok     = (f1_status_ff == htfc_pkg::LINK_OK);

      item.link_status = f1_status_ff;
      item.temp_good   = link_ok && (temp_crc == f1_temp_check_ff);
      item.hum_good    = link_ok && (hum_crc == f1_hum_check_ff);
      item.temp_value  = temp_scaled + htfc_pkg::TEMP_OFFSET;
      item.hum_value   = hum_scaled[6:0];
   end

endmodule

FILE: hw/rtl/htfc_back.sv
// Back part: error counters, last good values, averaging windows and result.
module htfc_back #(
   parameter int AVG_DEPTH = htfc_pkg::AVG_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  htfc_pkg::htfc_cfg_type    cfg,
   input  logic                      item_valid,
   input  htfc_pkg::htfc_item_type   item,
   output logic                      item_pop,
   output logic                      result_push,
   output htfc_pkg::htfc_result_type result,
   input  logic                      result_full
);

   localparam int SUM_W   = $clog2(htfc_pkg::TEMP_MAX * AVG_DEPTH + 1);
   localparam int DIV_SH  = SUM_W + $clog2(AVG_DEPTH);
   localparam int RECIP_W = DIV_SH + 1;
   localparam int MUL_W   = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

   logic [7:0]       temp_last_ff, temp_last_in;
   logic [6:0]       hum_last_ff, hum_last_in;
   logic [7:0]       temp_win_ff [AVG_DEPTH];
   logic [7:0]       temp_win_in [AVG_DEPTH];
   logic [6:0]       hum_win_ff [AVG_DEPTH];
   logic [6:0]       hum_win_in [AVG_DEPTH];
   logic [SUM_W-1:0] temp_sum_ff, temp_sum_in;
   logic [SUM_W-1:0] hum_sum_ff, hum_sum_in;
   logic [15:0]      temp_err_ff, temp_err_in;
   logic [15:0]      hum_err_ff, hum_err_in;
   logic [7:0]       link_err_ff, link_err_in;
   logic             error_flag_ff, error_flag_in;
   logic             req;

   logic             b2_valid_ff;
   logic [SUM_W-1:0] b2_temp_sum_ff, b2_hum_sum_ff;
   logic             b2_temp_good_ff, b2_hum_good_ff;
   logic             b2_error_ff, b2_req_ff;
   logic [MUL_W-1:0] temp_mul, hum_mul;

   assign item_pop    = item_valid && (!b2_valid_ff || !result_full);
   assign result_push = b2_valid_ff && !result_full;

   always_comb begin
      temp_last_in = temp_last_ff;
      hum_last_in  = hum_last_ff;
      temp_err_in  = temp_err_ff;
      hum_err_in   = hum_err_ff;
      link_err_in  = link_err_ff;
      req          = 1'b0;

      if (item.link_status == htfc_pkg::LINK_OK) begin
         if (item.temp_good) begin
            temp_last_in = item.temp_value;
         end else if (temp_err_ff != '1) begin
            temp_err_in = temp_err_ff + 16'd1;
         end
         if (item.hum_good) begin
            hum_last_in = item.hum_value;
         end else if (hum_err_ff != '1) begin
            hum_err_in = hum_err_ff + 16'd1;
         end
      end else if (link_err_ff != '1) begin
         link_err_in = link_err_ff + 8'd1;
      end

      // An address or command high NACK skips the CRC counter check.
      if ((item.link_status == htfc_pkg::LINK_OK ||
           item.link_status == htfc_pkg::LINK_CMDL_NACK) &&
          (temp_err_in >= 16'(cfg.error_limit) || hum_err_in >= 16'(cfg.error_limit))) begin
         req = 1'b1;
      end
      if (link_err_in >= cfg.error_limit) begin
         link_err_in = cfg.error_limit;
         req         = 1'b1;
      end
      error_flag_in = error_flag_ff | req;

      for (int i = 0; i < AVG_DEPTH - 1; i++) begin
         temp_win_in[i] = temp_win_ff[i+1];
         hum_win_in[i]  = hum_win_ff[i+1];
      end
      temp_win_in[AVG_DEPTH-1] = temp_last_in;
      hum_win_in[AVG_DEPTH-1]  = hum_last_in;

      // Running sums: the oldest entry leaves as the new value comes in.
      temp_sum_in = temp_sum_ff - SUM_W'(temp_win_ff[0]) + SUM_W'(temp_last_in);
      hum_sum_in  = hum_sum_ff - SUM_W'(hum_win_ff[0]) + SUM_W'(hum_last_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_last_ff  <= '0;
         hum_last_ff   <= '0;
         temp_sum_ff   <= '0;
         hum_sum_ff    <= '0;
         temp_err_ff   <= '0;
         hum_err_ff    <= '0;
         link_err_ff   <= '0;
         error_flag_ff <= 1'b0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            temp_win_ff[i] <= '0;
            hum_win_ff[i]  <= '0;
         end
      end else if (item_pop) begin
         temp_last_ff  <= temp_last_in;
         hum_last_ff   <= hum_last_in;
         temp_sum_ff   <= temp_sum_in;
         hum_sum_ff    <= hum_sum_in;
         temp_err_ff   <= temp_err_in;
         hum_err_ff    <= hum_err_in;
         link_err_ff   <= link_err_in;
         error_flag_ff <= error_flag_in;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            temp_win_ff[i] <= temp_win_in[i];
            hum_win_ff[i]  <= hum_win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else if (item_pop) begin
         b2_valid_ff <= 1'b1;
      end else if (result_push) begin
         b2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         b2_temp_sum_ff  <= temp_sum_in;
         b2_hum_sum_ff   <= hum_sum_in;
         b2_temp_good_ff <= item.temp_good;
         b2_hum_good_ff  <= item.hum_good;
         b2_error_ff     <= error_flag_in;
         b2_req_ff       <= req;
      end
   end

   // Mean by multiplying with a rounded-up reciprocal; exact over the sum range.
   always_comb begin
      temp_mul = MUL_W'(b2_temp_sum_ff) * MUL_W'(RECIP);
      hum_mul  = MUL_W'(b2_hum_sum_ff) * MUL_W'(RECIP);

      result.temp_average  = temp_mul[DIV_SH +: 8];
      result.hum_average   = hum_mul[DIV_SH +: 7];
      result.temp_good     = b2_temp_good_ff;
      result.hum_good      = b2_hum_good_ff;
      result.sensor_error  = b2_error_ff;
      result.reset_request = b2_req_ff;
   end

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      error_flag_ff |=> error_flag_ff)
      else $error("error flag cleared without reset");

   a_req_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (item_pop && req) |=> (error_flag_ff && b2_req_ff && b2_error_ff))
      else $error("reset request did not set the error flag");

   a_temp_sum_range: assert property (@(posedge clock) disable iff (reset)
      temp_sum_ff <= SUM_W'(htfc_pkg::TEMP_MAX * AVG_DEPTH))
      else $error("temperature window sum out of range");

   a_hum_sum_range: assert property (@(posedge clock) disable iff (reset)
      hum_sum_ff <= SUM_W'(htfc_pkg::HUM_SCALE * AVG_DEPTH))
      else $error("humidity window sum out of range");

endmodule

FILE: hw/rtl/humidity_temperature_frame_checker_unit.sv
// Top level of the humidity/temperature frame checker.
// Each accepted frame gives exactly one result item, in order. The block takes one frame
// per cycle for as long as neither queue fills; the figure is set by the back part, whose
// counter, last-value and window update is worked out as each item is popped. A result
// passes the input register, where the CRCs and scaling are worked out, the queue between
// front and back, the averaging stage and the result queue before it shows on the result
// ports. A queue of QUEUE_DEPTH items sits between front and back and another holds
// finished results, so a stalled reader does not stop frames from being taken until both
// fill. Configuration writes are taken in any cycle, but are only to be made while no
// frame is in flight.
module humidity_temperature_frame_checker_unit #(
   parameter int AVG_DEPTH   = htfc_pkg::AVG_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH = htfc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_link_status,
   input  logic [15:0] req_temp_word,
   input  logic [7:0]  req_temp_check,
   input  logic [15:0] req_hum_word,
   input  logic [7:0]  req_hum_check,

   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_temp_average,
   output logic [6:0]  rsp_hum_average,
   output logic        rsp_temp_good,
   output logic        rsp_hum_good,
   output logic        rsp_sensor_error,
   output logic        rsp_reset_request,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   htfc_pkg::htfc_cfg_type    cfg_ff;
   htfc_pkg::htfc_frame_type  frame;
   htfc_pkg::htfc_item_type   front_item, back_item;
   htfc_pkg::htfc_result_type back_result, head_result;
   logic                      front_push, mid_full, mid_empty, back_pop;
   logic                      result_push, result_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_poly    <= htfc_pkg::CRC_POLY_RESET;
         cfg_ff.error_limit <= htfc_pkg::ERROR_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            htfc_pkg::CSR_CRC_POLY:    cfg_ff.crc_poly    <= csr_data;
            htfc_pkg::CSR_ERROR_LIMIT: cfg_ff.error_limit <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      frame.link_status = req_link_status;
      frame.temp_word   = req_temp_word;
      frame.temp_check  = req_temp_check;
      frame.hum_word    = req_hum_word;
      frame.hum_check   = req_hum_check;
   end

   htfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_valid (push),
      .frame       (frame),
      .frame_full  (full),
      .item_push   (front_push),
      .item        (front_item),
      .item_full   (mid_full)
   );

   htfc_fifo #(
      .WIDTH ($bits(htfc_pkg::htfc_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_item),
      .full    (mid_full),
      .pop     (back_pop),
      .rd_data (back_item),
      .empty   (mid_empty)
   );

   htfc_back #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_valid  (!mid_empty),
      .item        (back_item),
      .item_pop    (back_pop),
      .result_push (result_push),
      .result      (back_result),
      .result_full (result_full)
   );

   htfc_fifo #(
      .WIDTH ($bits(htfc_pkg::htfc_result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (result_push),
      .wr_data (back_result),
      .full    (result_full),
      .pop     (pop),
      .rd_data (head_result),
      .empty   (empty)
   );

   assign rsp_temp_average  = head_result.temp_average;
   assign rsp_hum_average   = head_result.hum_average;
   assign rsp_temp_good     = head_result.temp_good;
   assign rsp_hum_good      = head_result.hum_good;
   assign rsp_sensor_error  = head_result.sensor_error;
   assign rsp_reset_request = head_result.reset_request;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the humidity/temperature frame checker unit.
`timescale 1ns / 100ps

module testbench;

   localparam int HIST_DEPTH    = htfc_pkg::AVG_DEPTH_DEFAULT;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_link_status = htfc_pkg::LINK_OK;
   logic [15:0] req_temp_word = '0;
   logic [7:0]  req_temp_check = '0;
   logic [15:0] req_hum_word = '0;
   logic [7:0]  req_hum_check = '0;

   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_temp_average;
   logic [6:0]  rsp_hum_average;
   logic        rsp_temp_good;
   logic        rsp_hum_good;
   logic        rsp_sensor_error;
   logic        rsp_reset_request;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = htfc_pkg::CSR_CRC_POLY;
   logic [7:0]  csr_data = '0;

   humidity_temperature_frame_checker_unit #(
      .AVG_DEPTH (HIST_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_link_status   (req_link_status),
      .req_temp_word     (req_temp_word),
      .req_temp_check    (req_temp_check),
      .req_hum_word      (req_hum_word),
      .req_hum_check     (req_hum_check),
      .empty             (empty),
      .pop               (pop),
      .rsp_temp_average  (rsp_temp_average),
      .rsp_hum_average   (rsp_hum_average),
      .rsp_temp_good     (rsp_temp_good),
      .rsp_hum_good      (rsp_hum_good),
      .rsp_sensor_error  (rsp_sensor_error),
      .rsp_reset_request (rsp_reset_request),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mirror of the block's configuration and state.
   logic [7:0]  cfg_poly = htfc_pkg::CRC_POLY_RESET;
   logic [7:0]  cfg_limit = htfc_pkg::ERROR_LIMIT_RESET;
   logic [7:0]  temp_last = '0;
   logic [7:0]  hum_last = '0;
   logic [7:0]  temp_hist [HIST_DEPTH];
   logic [7:0]  hum_hist [HIST_DEPTH];
   logic [15:0] temp_errs = '0;
   logic [15:0] hum_errs = '0;
   logic [7:0]  link_errs = '0;
   logic        sticky_error = 1'b0;

   htfc_pkg::htfc_frame_type  pending_frames [$];
   htfc_pkg::htfc_result_type expected_results [$];
   htfc_pkg::htfc_frame_type  frame_on_port;

   int send_wait = 0;
   int take_wait = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int send_gap_max = 8;
   int take_gap_max = 8;
   int frames_accepted = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   logic next_pop;
   htfc_pkg::htfc_result_type want;

   initial begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         temp_hist[i] = '0;
         hum_hist[i] = '0;
      end
   end

   function automatic logic [7:0] crc8_of_word(logic [15:0] word, logic [7:0] poly);
      logic [7:0] crc;
      logic       top;
      crc = htfc_pkg::CRC_INIT;
      for (int b = 15; b >= 0; b--) begin
         top = crc[7];
         crc = {crc[6:0], 1'b0};
         if (top ^ word[b]) crc = crc ^ poly;
      end
      return crc;
   endfunction

   // Works out the result item of one frame and advances the mirrored state.
   function automatic htfc_pkg::htfc_result_type predict_frame(htfc_pkg::htfc_frame_type f);
      htfc_pkg::htfc_result_type r;
      logic            raise;
      int              temp_sum;
      int              hum_sum;
      r = '0;
      raise = 1'b0;
      if (f.link_status == htfc_pkg::LINK_OK) begin
         if (crc8_of_word(f.temp_word, cfg_poly) == f.temp_check) begin
            r.temp_good = 1'b1;
            temp_last = 8'(int'(f.temp_word) * htfc_pkg::TEMP_SCALE / htfc_pkg::SCALE_DIV
                           + int'(htfc_pkg::TEMP_OFFSET));
         end else if (temp_errs != 16'hFFFF) begin
            temp_errs++;
         end
         if (crc8_of_word(f.hum_word, cfg_poly) == f.hum_check) begin
            r.hum_good = 1'b1;
            hum_last = 8'(int'(f.hum_word) * htfc_pkg::HUM_SCALE / htfc_pkg::SCALE_DIV);
         end else if (hum_errs != 16'hFFFF) begin
            hum_errs++;
         end
      end else if (link_errs != 8'hFF) begin
         link_errs++;
      end
      // A command low nack still has the word counters compared with the limit.
      if ((f.link_status == htfc_pkg::LINK_OK ||
           f.link_status == htfc_pkg::LINK_CMDL_NACK) &&
          (temp_errs >= cfg_limit || hum_errs >= cfg_limit)) raise = 1'b1;
      if (link_errs >= cfg_limit) begin
         link_errs = cfg_limit;
         raise = 1'b1;
      end
      if (raise) sticky_error = 1'b1;
      temp_sum = 0;
      hum_sum = 0;
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
         temp_hist[i] = temp_hist[i + 1];
         hum_hist[i] = hum_hist[i + 1];
      end
      temp_hist[HIST_DEPTH - 1] = temp_last;
      hum_hist[HIST_DEPTH - 1] = hum_last;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         temp_sum += temp_hist[i];
         hum_sum += hum_hist[i];
      end
      r.temp_average = 8'(temp_sum / HIST_DEPTH);
      r.hum_average = 7'(hum_sum / HIST_DEPTH);
      r.sensor_error = sticky_error;
      r.reset_request = raise;
      return r;
   endfunction

   // A bad check is the right CRC with at least one bit flipped.
   function automatic htfc_pkg::htfc_frame_type build_frame(logic [1:0] status,
                                                            logic [15:0] tw, logic [15:0] hw,
                                                            bit t_bad, bit h_bad);
      htfc_pkg::htfc_frame_type f;
      f.link_status = status;
      f.temp_word = tw;
      f.hum_word = hw;
      f.temp_check = crc8_of_word(tw, cfg_poly) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
      f.hum_check = crc8_of_word(hw, cfg_poly) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
      return f;
   endfunction

   function automatic logic [15:0] random_word();
      logic [15:0] corner [4];
      corner = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
      if ($urandom_range(0, 19) == 0) return corner[2'($urandom_range(0, 3))];
      return 16'($urandom());
   endfunction

   function automatic htfc_pkg::htfc_frame_type random_frame(int nack_pct, int bad_pct);
      logic [1:0] nack_codes [3];
      logic [1:0] status;
      nack_codes = '{htfc_pkg::LINK_ADDR_NACK, htfc_pkg::LINK_CMDH_NACK,
                     htfc_pkg::LINK_CMDL_NACK};
      status = htfc_pkg::LINK_OK;
      if ($urandom_range(0, 99) < nack_pct) status = nack_codes[2'($urandom_range(0, 2))];
      return build_frame(status, random_word(), random_word(),
                         $urandom_range(0, 99) < bad_pct, $urandom_range(0, 99) < bad_pct);
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", results_checked, what);
      mismatch_count++;
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == htfc_pkg::CSR_CRC_POLY) cfg_poly = value;
      else cfg_limit = value;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_frames.size() != 0 || push || expected_results.size() != 0);
   endtask

   task automatic run_phase(logic [7:0] poly, logic [7:0] limit, int count,
                            int nack_pct, int bad_pct, int gap);
      wait_drained();
      write_csr(htfc_pkg::CSR_CRC_POLY, poly);
      write_csr(htfc_pkg::CSR_ERROR_LIMIT, limit);
      @(negedge clock);
      send_gap_max = gap;
      take_gap_max = gap;
      for (int i = 0; i < count; i++) pending_frames.push_back(random_frame(nack_pct, bad_pct));
   endtask

   // Sender: offers one item at a time, holding it while the block is full.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_results.push_back(predict_frame(frame_on_port));
            frames_accepted++;
         end
         if (!(push && full)) begin
            if (send_wait > 0) begin
               send_wait--;
               push <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               frame_on_port = pending_frames.pop_front();
               req_link_status <= frame_on_port.link_status;
               req_temp_word <= frame_on_port.temp_word;
               req_temp_check <= frame_on_port.temp_check;
               req_hum_word <= frame_on_port.hum_word;
               req_hum_check <= frame_on_port.hum_check;
               push <= 1'b1;
               send_wait = $urandom_range(0, send_gap_max);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result item against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               report_mismatch("result item with no frame outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_temp_average !== want.temp_average)
                  report_mismatch($sformatf("temp_average expected %0d got %0d",
                                            want.temp_average, rsp_temp_average));
               if (rsp_hum_average !== want.hum_average)
                  report_mismatch($sformatf("hum_average expected %0d got %0d",
                                            want.hum_average, rsp_hum_average));
               if (rsp_temp_good !== want.temp_good)
                  report_mismatch($sformatf("temp_good expected %0b got %0b",
                                            want.temp_good, rsp_temp_good));
               if (rsp_hum_good !== want.hum_good)
                  report_mismatch($sformatf("hum_good expected %0b got %0b",
                                            want.hum_good, rsp_hum_good));
               if (rsp_sensor_error !== want.sensor_error)
                  report_mismatch($sformatf("sensor_error expected %0b got %0b",
                                            want.sensor_error, rsp_sensor_error));
               if (rsp_reset_request !== want.reset_request)
                  report_mismatch($sformatf("reset_request expected %0b got %0b",
                                            want.reset_request, rsp_reset_request));
            end
            take_wait = $urandom_range(0, take_gap_max);
            // One long hold-off lets both internal queues fill and stall the input.
            if (results_checked == HOLD_AT && !hold_done) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            next_pop = 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            next_pop = 1'b0;
         end else begin
            next_pop = 1'b1;
         end
         pop <= next_pop;
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int          worst;
      logic [7:0]  limit_near;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames with the limit out of the way.
      wait_drained();
      write_csr(htfc_pkg::CSR_CRC_POLY, htfc_pkg::CRC_POLY_RESET);
      write_csr(htfc_pkg::CSR_ERROR_LIMIT, 8'd255);
      @(negedge clock);
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'h0000, 16'h0000, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'h7FFF, 16'h8000, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'h8000, 16'h7FFF, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'hFFFE, 16'hFFFE, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'h0001, 16'h0001, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'h5A5A, 16'hA5A5, 1'b1, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'hA5A5, 16'h5A5A, 1'b0, 1'b1));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'h1234, 16'hBEEF, 1'b1, 1'b1));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_ADDR_NACK,
                                           16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_CMDH_NACK,
                                           16'h0000, 16'hFFFF, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_CMDL_NACK,
                                           16'hFFFF, 16'h0000, 1'b1, 1'b1));
      // Saturate both windows to reach the top of both averages.
      for (int i = 0; i < HIST_DEPTH; i++)
         pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'hFFFF, 16'hFFFF,
                                              1'b0, 1'b0));
      pending_frames.push_back(build_frame(htfc_pkg::LINK_OK, 16'h0000, 16'h0000, 1'b0, 1'b0));

      run_phase(8'($urandom_range(1, 254)), 8'd255, 450, 2, 4, 8);

      // Put the limit just above the busiest counter so the error flag rises mid-phase.
      wait_drained();
      worst = temp_errs;
      if (hum_errs > worst) worst = hum_errs;
      if (link_errs > worst) worst = link_errs;
      limit_near = (worst + 8 > 255) ? 8'd255 : 8'(worst + 8);
      run_phase(8'h00, limit_near, 300, 10, 10, 0);
      run_phase(8'hFF, 8'd1, 300, 20, 20, 8);
      run_phase(8'($urandom_range(1, 254)), 8'd255, 380, 5, 5, 8);
      run_phase(htfc_pkg::CRC_POLY_RESET, htfc_pkg::ERROR_LIMIT_RESET, 300, 10, 10, 3);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) report_mismatch("results still outstanding at the end");
      $display("Ran %0d frames and checked %0d result items over %0d register writes.",
               frames_accepted, results_checked, csr_writes);
      $display("Covered every link status, polynomials 0x00, 0xff and random, limits 1 to 255.");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: humidity_temperature_frame_checker_unit.f
hw/rtl/htfc_pkg.sv
hw/rtl/htfc_fifo.sv
hw/rtl/htfc_front.sv
hw/rtl/htfc_back.sv
hw/rtl/humidity_temperature_frame_checker_unit.sv
bench/testbench.sv
